@@ rtl/core/pdw_pkg.sv @@
// Package for the page descriptor writer: item structs, mode codes,
// sequencer states and descriptor constants.
// Depends on nothing; used by page_descriptor_writer_top and the verif benches.
package pdw_pkg;

    // Mapping modes carried in the command item
    typedef enum logic [2:0] {
        MODE_SECTION       = 3'd0,
        MODE_COARSE_LARGE  = 3'd1,
        MODE_COARSE_SMALL  = 3'd2,
        MODE_FINE_LARGE    = 3'd3,
        MODE_FINE_SMALL    = 3'd4,
        MODE_FINE_TINY     = 3'd5,
        MODE_ATTACH_COARSE = 3'd6,
        MODE_ATTACH_FINE   = 3'd7
    } mode_t;

    // Sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // One command item
    typedef struct packed {
        mode_t       mode;
        logic [31:0] table_base;
        logic [31:0] region_virt;
        logic [31:0] region_phys;
        logic [11:0] page_index;
        logic [1:0]  access_perm;
        logic [1:0]  cache_bits;
        logic [3:0]  domain;
    } cmd_t;

    // One memory write result item
    typedef struct packed {
        logic [31:0] write_addr;
        logic [31:0] write_data;
        logic        last_write;
    } result_t;

    localparam logic [31:0] MASK_1M   = 32'hfff00000;
    localparam logic [31:0] MASK_64K  = 32'hffff0000;
    localparam logic [31:0] MASK_4K   = 32'hfffff000;
    localparam logic [31:0] MASK_1K   = 32'hfffffc00;
    localparam logic [31:0] TYPE_ATTACH_COARSE = 32'h00000011;
    localparam logic [31:0] TYPE_ATTACH_FINE   = 32'h00000013;
    localparam logic [31:0] TYPE_SECTION       = 32'h00000012;
    localparam logic [31:0] TYPE_LARGE         = 32'h00000001;
    localparam logic [31:0] TYPE_SMALL         = 32'h00000002;
    localparam logic [31:0] TYPE_TINY          = 32'h00000003;

    // Index masks for table sizes
    localparam logic [11:0] IDX_MASK_MASTER = 12'hfff;
    localparam logic [11:0] IDX_MASK_FINE   = 12'h3ff;
    localparam logic [11:0] IDX_MASK_COARSE = 12'h0ff;

endpackage

@@ rtl/core/page_descriptor_writer_top.sv @@
// Page descriptor writer: one command item in, 1 to 64 descriptor writes out.
// Depends on pdw_pkg for item structs, mode codes and constants.
//
// Start moves the sequencer to CALC, then EMIT, and each write is registered
// onto done; one write per cycle after the first. Busy holds through CALC and
// EMIT, and one shared 32-bit adder builds the descriptor, then each address.
// Results are strobed for one cycle on done and cannot be stalled.
// Reset clears the sequencer and the done strobe; no memory to sweep.
module page_descriptor_writer_top
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  pdw_pkg::cmd_t   cmd,
    output logic            done,
    output pdw_pkg::result_t result
);

    pdw_pkg::state_t  state_reg, state_next;
    pdw_pkg::cmd_t    cmd_reg;
    logic [31:0]      data_reg, data_next;
    logic [11:0]      idx_reg, idx_next;
    logic [11:0]      mask_reg, mask_next;
    logic [5:0]       count_reg, count_next;
    logic             done_reg, done_next;
    pdw_pkg::result_t result_reg, result_next;

    // Per-mode decode of the latched item
    logic [31:0] base_desc;
    logic [31:0] page_add;
    logic [11:0] start_idx;
    logic [11:0] page_step;
    logic [11:0] idx_mask;
    logic [5:0]  last_count;
    logic [31:0] ap4;

    // Shared adder
    logic [31:0] op_a, op_b, sum;

    logic        accept;
    logic [11:0] idx_wrapped;

    assign accept = start && (state_reg == pdw_pkg::ST_IDLE);
    assign busy   = (state_reg != pdw_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign ap4 = {20'd0, cmd_reg.access_perm, cmd_reg.access_perm,
                  cmd_reg.access_perm, cmd_reg.access_perm, 4'd0};

    // Descriptor, start index and copy count per mode
    always_comb
    begin
        base_desc  = '0;
        page_add   = '0;
        start_idx  = '0;
        page_step  = '0;
        idx_mask   = pdw_pkg::IDX_MASK_MASTER;
        last_count = '0;
        unique case (cmd_reg.mode)
            pdw_pkg::MODE_SECTION:
            begin
                base_desc = (cmd_reg.region_phys & pdw_pkg::MASK_1M)
                          | {20'd0, cmd_reg.access_perm, 10'd0}
                          | {23'd0, cmd_reg.domain, 5'd0}
                          | {28'd0, cmd_reg.cache_bits, 2'd0}
                          | pdw_pkg::TYPE_SECTION;
                page_add  = {cmd_reg.page_index, 20'd0};
                start_idx = cmd_reg.region_virt[31:20];
                page_step = cmd_reg.page_index;
            end
            pdw_pkg::MODE_ATTACH_COARSE:
            begin
                base_desc = (cmd_reg.region_phys & pdw_pkg::MASK_1K)
                          | {23'd0, cmd_reg.domain, 5'd0}
                          | pdw_pkg::TYPE_ATTACH_COARSE;
                start_idx = cmd_reg.region_virt[31:20];
            end
            pdw_pkg::MODE_ATTACH_FINE:
            begin
                base_desc = (cmd_reg.region_phys & pdw_pkg::MASK_4K)
                          | {23'd0, cmd_reg.domain, 5'd0}
                          | pdw_pkg::TYPE_ATTACH_FINE;
                start_idx = cmd_reg.region_virt[31:20];
            end
            pdw_pkg::MODE_COARSE_LARGE:
            begin
                base_desc  = (cmd_reg.region_phys & pdw_pkg::MASK_64K) | ap4
                           | {28'd0, cmd_reg.cache_bits, 2'd0} | pdw_pkg::TYPE_LARGE;
                page_add   = {4'd0, cmd_reg.page_index, 16'd0};
                start_idx  = {4'd0, cmd_reg.region_virt[19:12]};
                page_step  = {cmd_reg.page_index[7:0], 4'd0};
                idx_mask   = pdw_pkg::IDX_MASK_COARSE;
                last_count = 6'd15;
            end
            pdw_pkg::MODE_COARSE_SMALL:
            begin
                base_desc = (cmd_reg.region_phys & pdw_pkg::MASK_4K) | ap4
                          | {28'd0, cmd_reg.cache_bits, 2'd0} | pdw_pkg::TYPE_SMALL;
                page_add  = {8'd0, cmd_reg.page_index, 12'd0};
                start_idx = {4'd0, cmd_reg.region_virt[19:12]};
                page_step = cmd_reg.page_index;
                idx_mask  = pdw_pkg::IDX_MASK_COARSE;
            end
            pdw_pkg::MODE_FINE_LARGE:
            begin
                base_desc  = (cmd_reg.region_phys & pdw_pkg::MASK_64K) | ap4
                           | {28'd0, cmd_reg.cache_bits, 2'd0} | pdw_pkg::TYPE_LARGE;
                page_add   = {4'd0, cmd_reg.page_index, 16'd0};
                start_idx  = {2'd0, cmd_reg.region_virt[19:10]};
                page_step  = {cmd_reg.page_index[5:0], 6'd0};
                idx_mask   = pdw_pkg::IDX_MASK_FINE;
                last_count = 6'd63;
            end
            pdw_pkg::MODE_FINE_SMALL:
            begin
                base_desc  = (cmd_reg.region_phys & pdw_pkg::MASK_4K) | ap4
                           | {28'd0, cmd_reg.cache_bits, 2'd0} | pdw_pkg::TYPE_SMALL;
                page_add   = {8'd0, cmd_reg.page_index, 12'd0};
                start_idx  = {2'd0, cmd_reg.region_virt[19:10]};
                page_step  = {cmd_reg.page_index[9:0], 2'd0};
                idx_mask   = pdw_pkg::IDX_MASK_FINE;
                last_count = 6'd3;
            end
            pdw_pkg::MODE_FINE_TINY:
            begin
                base_desc = (cmd_reg.region_phys & pdw_pkg::MASK_1K)
                          | {26'd0, cmd_reg.access_perm, 4'd0}
                          | {28'd0, cmd_reg.cache_bits, 2'd0} | pdw_pkg::TYPE_TINY;
                page_add  = {10'd0, cmd_reg.page_index, 10'd0};
                start_idx = {2'd0, cmd_reg.region_virt[19:10]};
                page_step = cmd_reg.page_index;
                idx_mask  = pdw_pkg::IDX_MASK_FINE;
            end
            default:
            begin
                base_desc = '0;
            end
        endcase
    end

    assign idx_wrapped = idx_reg & mask_reg;

    // Shared adder: descriptor offset in CALC, write address in EMIT
    always_comb
    begin
        if (state_reg == pdw_pkg::ST_CALC)
        begin
            op_a = base_desc;
            op_b = page_add;
        end
        else
        begin
            op_a = cmd_reg.table_base;
            op_b = {18'd0, idx_wrapped, 2'd0};
        end
    end

    assign sum = op_a + op_b;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        data_next   = data_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            pdw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pdw_pkg::ST_CALC;
                end
            end
            pdw_pkg::ST_CALC:
            begin
                data_next  = sum;
                idx_next   = start_idx + page_step;
                mask_next  = idx_mask;
                count_next = last_count;
                state_next = pdw_pkg::ST_EMIT;
            end
            pdw_pkg::ST_EMIT:
            begin
                done_next              = 1'b1;
                result_next.write_addr = sum;
                result_next.write_data = data_reg;
                result_next.last_write = (count_reg == 6'd0);
                idx_next               = idx_reg + 12'd1;
                count_next             = count_reg - 6'd1;
                if (count_reg == 6'd0)
                begin
                    state_next = pdw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdw_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        data_reg   <= data_next;
        idx_reg    <= idx_next;
        mask_reg   <= mask_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

endmodule

@@ verif/pdw_write_check.sv @@
// Write checker for the page descriptor writer: predicts the descriptor writes of
// each accepted command item and compares every strobed write against them in order.
// Depends on pdw_pkg for the item structs, mode codes and descriptor constants.
`timescale 1ns / 100ps

module pdw_write_check
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  pdw_pkg::cmd_t    cmd,
    input  logic             done,
    input  pdw_pkg::result_t result,
    output int               fail_count,
    output int               writes_outstanding
);

    // Virtual address bits that select the first entry of a second-level table
    localparam logic [31:0] VIRT_COARSE_BITS = 32'h000ff000;
    localparam logic [31:0] VIRT_FINE_BITS   = 32'h000ffc00;
    localparam int          MAX_PRINTED      = 40;

    pdw_pkg::result_t expected_writes[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < MAX_PRINTED)
        begin
            $display("%0t ns: write mismatch on %s: got %h, expected %h",
                     $time, what, got, want);
        end
        fail_count++;
    endtask

    // Build the descriptor for one page and queue each replicated write
    function automatic void predict_page_writes(input pdw_pkg::cmd_t c);
        logic [31:0]      ap32, cb32, dom32, page32, ap_all;
        logic [31:0]      descriptor, first_entry, page_offset, idx_mask, entry;
        int               copies;
        pdw_pkg::result_t w;
        ap32   = {30'd0, c.access_perm};
        cb32   = {30'd0, c.cache_bits};
        dom32  = {28'd0, c.domain};
        page32 = {20'd0, c.page_index};
        ap_all = (ap32 << 10) | (ap32 << 8) | (ap32 << 6) | (ap32 << 4);
        copies = 1;
        case (c.mode) inside
            pdw_pkg::MODE_SECTION:
            begin
                descriptor  = ((c.region_phys & pdw_pkg::MASK_1M) | (ap32 << 10)
                              | (dom32 << 5) | (cb32 << 2) | pdw_pkg::TYPE_SECTION)
                              + (page32 << 20);
                first_entry = c.region_virt >> 20;
                idx_mask    = {20'd0, pdw_pkg::IDX_MASK_MASTER};
            end
            pdw_pkg::MODE_ATTACH_COARSE, pdw_pkg::MODE_ATTACH_FINE:
            begin
                if (c.mode == pdw_pkg::MODE_ATTACH_COARSE)
                    descriptor = (c.region_phys & pdw_pkg::MASK_1K) | (dom32 << 5)
                                 | pdw_pkg::TYPE_ATTACH_COARSE;
                else
                    descriptor = (c.region_phys & pdw_pkg::MASK_4K) | (dom32 << 5)
                                 | pdw_pkg::TYPE_ATTACH_FINE;
                first_entry = c.region_virt >> 20;
                idx_mask    = {20'd0, pdw_pkg::IDX_MASK_MASTER};
                // page, AP and C/B play no part here
                page32      = '0;
            end
            pdw_pkg::MODE_COARSE_LARGE, pdw_pkg::MODE_COARSE_SMALL:
            begin
                first_entry = (c.region_virt & VIRT_COARSE_BITS) >> 12;
                idx_mask    = {20'd0, pdw_pkg::IDX_MASK_COARSE};
                if (c.mode == pdw_pkg::MODE_COARSE_LARGE)
                begin
                    copies     = 16;
                    descriptor = ((c.region_phys & pdw_pkg::MASK_64K) | ap_all
                                 | (cb32 << 2) | pdw_pkg::TYPE_LARGE) + (page32 << 16);
                end
                else
                begin
                    descriptor = ((c.region_phys & pdw_pkg::MASK_4K) | ap_all
                                 | (cb32 << 2) | pdw_pkg::TYPE_SMALL) + (page32 << 12);
                end
            end
            default:
            begin
                // fine table: large, small or tiny page
                first_entry = (c.region_virt & VIRT_FINE_BITS) >> 10;
                idx_mask    = {20'd0, pdw_pkg::IDX_MASK_FINE};
                if (c.mode == pdw_pkg::MODE_FINE_LARGE)
                begin
                    copies     = 64;
                    descriptor = ((c.region_phys & pdw_pkg::MASK_64K) | ap_all
                                 | (cb32 << 2) | pdw_pkg::TYPE_LARGE) + (page32 << 16);
                end
                else if (c.mode == pdw_pkg::MODE_FINE_SMALL)
                begin
                    copies     = 4;
                    descriptor = ((c.region_phys & pdw_pkg::MASK_4K) | ap_all
                                 | (cb32 << 2) | pdw_pkg::TYPE_SMALL) + (page32 << 12);
                end
                else
                begin
                    descriptor = ((c.region_phys & pdw_pkg::MASK_1K) | (ap32 << 4)
                                 | (cb32 << 2) | pdw_pkg::TYPE_TINY) + (page32 << 10);
                end
            end
        endcase
        page_offset = page32 * copies;
        for (int j = 0; j < copies; j++)
        begin
            // index wraps at the table size, address wraps at 32 bits
            entry        = (first_entry + page_offset + j) & idx_mask;
            w.write_addr = c.table_base + (entry << 2);
            w.write_data = descriptor;
            w.last_write = (j == copies - 1);
            expected_writes.push_back(w);
        end
    endfunction

    // Compare strobed writes first, then queue the writes of a newly taken item
    always @(posedge clk)
    begin
        pdw_pkg::result_t want;
        if (!rst_n)
        begin
            expected_writes.delete();
            writes_outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_writes.size() == 0)
                begin
                    report_mismatch("unexpected write (addr)", result.write_addr, 32'h0);
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (result.write_addr !== want.write_addr)
                        report_mismatch("write_addr", result.write_addr, want.write_addr);
                    if (result.write_data !== want.write_data)
                        report_mismatch("write_data", result.write_data, want.write_data);
                    if (result.last_write !== want.last_write)
                        report_mismatch("last_write", {31'd0, result.last_write},
                                        {31'd0, want.last_write});
                end
            end
            if (start && !busy)
                predict_page_writes(cmd);
            writes_outstanding <= expected_writes.size();
        end
    end

endmodule

@@ verif/page_descriptor_writer_top_test.sv @@
// Testbench top for the page descriptor writer: clock, reset, command stimulus
// and the final verdict; checking is done by pdw_write_check.
// Depends on pdw_pkg, page_descriptor_writer_top and pdw_write_check.
`timescale 1ns / 100ps

module page_descriptor_writer_top_test;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 340;
    localparam int          CALM_ITEMS   = 60;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [31:0] ALL_ONES     = 32'hffffffff;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    pdw_pkg::cmd_t    cmd   = '0;
    logic             busy;
    logic             done;
    pdw_pkg::result_t result;
    int               write_failures;
    int               writes_outstanding;
    int               cycle_count = 0;

    page_descriptor_writer_top dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    pdw_write_check write_check
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .cmd                (cmd),
        .done               (done),
        .result             (result),
        .fail_count         (write_failures),
        .writes_outstanding (writes_outstanding)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("page_descriptor_writer_top regression: fail");
            $finish;
        end
    end

    function automatic pdw_pkg::cmd_t make_cmd(input pdw_pkg::mode_t m,
                                               input logic [31:0] base,
                                               input logic [31:0] virt,
                                               input logic [31:0] phys,
                                               input logic [11:0] page,
                                               input logic [1:0] ap,
                                               input logic [1:0] cb,
                                               input logic [3:0] dom);
        pdw_pkg::cmd_t c;
        c.mode        = m;
        c.table_base  = base;
        c.region_virt = virt;
        c.region_phys = phys;
        c.page_index  = page;
        c.access_perm = ap;
        c.cache_bits  = cb;
        c.domain      = dom;
        return c;
    endfunction

    // Half the items look like a real mapping (aligned tables, low page numbers),
    // the rest are random over every field
    function automatic pdw_pkg::cmd_t random_page_cmd();
        pdw_pkg::cmd_t c;
        c.mode        = pdw_pkg::mode_t'(3'($urandom_range(0, 7)));
        c.table_base  = $urandom;
        c.region_virt = $urandom;
        c.region_phys = $urandom;
        c.page_index  = 12'($urandom_range(0, 4095));
        c.access_perm = 2'($urandom_range(0, 3));
        c.cache_bits  = 2'($urandom_range(0, 3));
        c.domain      = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0)
        begin
            c.table_base  = c.table_base & 32'hffffc000;
            c.region_virt = c.region_virt & 32'hfffff000;
            c.region_phys = c.region_phys & 32'hfffff000;
            c.page_index  = 12'($urandom_range(0, 15));
        end
        return c;
    endfunction

    // Hold start high until the item is taken
    task automatic send_item(input pdw_pkg::cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Start low for a burst, with junk on the command bus
    task automatic idle_burst(input int cycles);
        repeat (cycles)
        begin
            start <= 1'b0;
            cmd   <= random_page_cmd();
            @(posedge clk);
        end
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 2) == 0)
            idle_burst($urandom_range(1, 10));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each mode at its extremes, wraps and unaligned starts
        send_item(make_cmd(pdw_pkg::MODE_SECTION, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_SECTION, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        maybe_idle();
        // section index and descriptor both wrap
        send_item(make_cmd(pdw_pkg::MODE_SECTION, 32'h10000000, 32'hfff00000,
                           32'hfff00000, 3, 1, 2, 5));
        send_item(make_cmd(pdw_pkg::MODE_COARSE_LARGE, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_COARSE_LARGE, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        maybe_idle();
        // large page start not aligned to 16 entries
        send_item(make_cmd(pdw_pkg::MODE_COARSE_LARGE, 32'h00004000, 32'h00003000,
                           32'h80000000, 2, 2, 1, 0));
        // runs off the end of the coarse table
        send_item(make_cmd(pdw_pkg::MODE_COARSE_LARGE, 32'h00008000, 32'h000ff000,
                           32'h12340000, 0, 1, 3, 0));
        send_item(make_cmd(pdw_pkg::MODE_COARSE_SMALL, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_COARSE_SMALL, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        maybe_idle();
        send_item(make_cmd(pdw_pkg::MODE_COARSE_SMALL, 32'h00010000, 32'h00001000,
                           32'hfffff000, 1, 2, 2, 0));
        send_item(make_cmd(pdw_pkg::MODE_FINE_LARGE, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_FINE_LARGE, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        send_item(make_cmd(pdw_pkg::MODE_FINE_LARGE, 32'h00020000, 32'h00000c00,
                           32'hffff0000, 1, 1, 1, 0));
        maybe_idle();
        send_item(make_cmd(pdw_pkg::MODE_FINE_SMALL, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_FINE_SMALL, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        send_item(make_cmd(pdw_pkg::MODE_FINE_SMALL, 32'h00030000, 32'h000ffc00,
                           32'h00402000, 0, 2, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_FINE_TINY, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_FINE_TINY, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        maybe_idle();
        send_item(make_cmd(pdw_pkg::MODE_FINE_TINY, 32'h00040000, 32'h00000400,
                           32'hfffffc00, 1, 3, 2, 0));
        send_item(make_cmd(pdw_pkg::MODE_ATTACH_COARSE, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_ATTACH_COARSE, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        send_item(make_cmd(pdw_pkg::MODE_ATTACH_FINE, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(pdw_pkg::MODE_ATTACH_FINE, ALL_ONES, ALL_ONES, ALL_ONES,
                           12'hfff, 3, 3, 15));
        // attach ignores page, AP and C/B
        send_item(make_cmd(pdw_pkg::MODE_ATTACH_COARSE, 32'h00100000, 32'h12345678,
                           32'h9abcdef0, 12'h5a5, 2, 1, 9));
        // table address wraps past 2^32
        send_item(make_cmd(pdw_pkg::MODE_FINE_LARGE, 32'hfffffff0, 0, 32'h00010000,
                           0, 1, 2, 0));

        // Random part; the last stretch runs back to back
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS - CALM_ITEMS)
                maybe_idle();
            send_item(random_page_cmd());
        end

        // Drain
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (writes_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (write_failures == 0)
            $display("page_descriptor_writer_top regression: pass");
        else
            $display("page_descriptor_writer_top regression: fail");
        $finish;
    end

endmodule
